// File: hw/rtl/sorted_array_priority_queue_top_macros.svh
// assertion macros used by the checker file
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_TOP_MACROS_SVH

// checked only while out of reset
`define SAPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define SAPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// File: hw/rtl/sapq_pkg.sv
// shared types, constants and controller/datapath interface of the priority queue
package sapq_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned CAP_MAX   = 127;
  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] out_value;
    logic signed [DATA_W-1:0] out_priority;
    logic [CNT_W-1:0]         entry_count;
  } out_item_t;

  // which logical slot the memory read fetches
  typedef enum logic [1:0] {
    RD_HEAD  = 2'd0,
    RD_PREV  = 2'd1,
    RD_PREV2 = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic       load;
    logic       cfg_we;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       wr_new;
    logic       wr_shift;
    logic       count_inc;
    logic       pop;
    logic       res_set;
    logic [1:0] res_status;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_deq;
    logic full;
    logic empty;
    logic pos_zero;
    logic pos_one;
    logic new_le;
  } dp_sts_t;

endpackage

// File: hw/rtl/sapq_ram.sv
// generic single write port, single read port ram with registered read data
module sapq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/sapq_ctrl.sv
// controller state machine of the priority queue
module sapq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  sapq_pkg::dp_sts_t sts_i,
  output sapq_pkg::dp_cmd_t cmd_o
);
  import sapq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_CMP   = 6'b000100,
    S_PUT   = 6'b001000,
    S_DEQ   = 6'b010000,
    S_DONE  = 6'b100000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        idle;
  dp_cmd_t     cmd;

  assign idle = (state_q == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = RD_HEAD;
    cmd.cfg_we  = cfg_valid_i && idle;
    state_d     = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_START;
        end
      end
      S_START: begin
        if (sts_i.is_deq) begin
          if (sts_i.empty) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_EMPTY;
            state_d        = S_DONE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_HEAD;
            state_d    = S_DEQ;
          end
        end else if (sts_i.full) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_FULL;
          state_d        = S_DONE;
        end else if (sts_i.pos_zero) begin
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_d    = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.new_le) begin
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          state_d       = S_DONE;
        end else begin
          // move the larger entry up one slot, fetch the next one down if any is left
          cmd.wr_shift = 1'b1;
          if (sts_i.pos_one) begin
            state_d = S_PUT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PREV2;
          end
        end
      end
      S_PUT: begin
        cmd.wr_new    = 1'b1;
        cmd.count_inc = 1'b1;
        state_d       = S_DONE;
      end
      S_DEQ: begin
        cmd.pop = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !idle;
  assign cfg_ready_o = idle;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: hw/rtl/sapq_dp.sv
// datapath of the priority queue: entry ring, counters, result and output registers
module sapq_dp #(
  parameter int unsigned DEPTH = sapq_pkg::DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sapq_pkg::in_item_t           in_data_i,
  input  logic [sapq_pkg::CNT_W-1:0]   cfg_data_i,
  input  sapq_pkg::dp_cmd_t            cmd_i,
  output sapq_pkg::dp_sts_t            sts_o,
  output sapq_pkg::out_item_t          out_data_o
);
  import sapq_pkg::*;

  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned SW        = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam int unsigned EW        = 2 * DATA_W;
  localparam int unsigned DEPTH_SAT = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;
  localparam logic [CNT_W-1:0] DEPTH_LIM = CNT_W'(DEPTH_SAT);
  localparam logic [SW-1:0]    DEPTH_S   = SW'(DEPTH);
  localparam logic [AW-1:0]    LAST_A    = AW'(DEPTH - 1);

  // logical slot to ring address, sum stays below twice the depth
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0]    base,
                                              input logic [CNT_W-1:0] idx);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(idx);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  logic [CNT_W-1:0]         cap_q, cap_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [AW-1:0]            head_q, head_d;
  logic [CNT_W-1:0]         pos_q, pos_d;
  in_item_t                 item_q, item_d;
  logic [1:0]               res_status_q, res_status_d;
  logic signed [DATA_W-1:0] res_val_q, res_val_d;
  logic signed [DATA_W-1:0] res_pri_q, res_pri_d;
  out_item_t                out_q, out_d;

  logic [CNT_W-1:0]         limit;
  logic [CNT_W-1:0]         rd_idx;
  logic [EW-1:0]            rd_word;
  logic signed [DATA_W-1:0] rd_pri;
  logic signed [DATA_W-1:0] rd_val;
  logic [EW-1:0]            wr_word;
  logic                     wr_en;

  assign limit  = (cap_q > DEPTH_LIM) ? DEPTH_LIM : cap_q;
  assign rd_pri = rd_word[EW-1:DATA_W];
  assign rd_val = rd_word[DATA_W-1:0];

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_HEAD:  rd_idx = '0;
      RD_PREV:  rd_idx = pos_q - CNT_W'(1);
      RD_PREV2: rd_idx = pos_q - CNT_W'(2);
      default:  rd_idx = '0;
    endcase
  end

  assign wr_en   = cmd_i.wr_new || cmd_i.wr_shift;
  assign wr_word = cmd_i.wr_shift ? rd_word : {item_q.item_priority, item_q.item_value};

  sapq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ring_addr(head_q, pos_q)),
    .wdata_i (wr_word),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ring_addr(head_q, rd_idx)),
    .rdata_o (rd_word)
  );

  always_comb begin
    cap_d        = cmd_i.cfg_we ? cfg_data_i : cap_q;
    count_d      = count_q;
    head_d       = head_q;
    pos_d        = pos_q;
    item_d       = item_q;
    res_status_d = res_status_q;
    res_val_d    = res_val_q;
    res_pri_d    = res_pri_q;
    out_d        = out_q;

    if (cmd_i.load) begin
      item_d       = in_data_i;
      pos_d        = count_q;
      res_status_d = ST_DONE;
      res_val_d    = '0;
      res_pri_d    = '0;
    end
    if (cmd_i.wr_shift) begin
      pos_d = pos_q - CNT_W'(1);
    end
    if (cmd_i.count_inc) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.pop) begin
      count_d   = count_q - CNT_W'(1);
      head_d    = (head_q == LAST_A) ? '0 : head_q + AW'(1);
      res_val_d = rd_val;
      res_pri_d = rd_pri;
    end
    if (cmd_i.res_set) begin
      res_status_d = cmd_i.res_status;
    end
    if (cmd_i.out_load) begin
      out_d.status       = res_status_q;
      out_d.out_value    = res_val_q;
      out_d.out_priority = res_pri_q;
      out_d.entry_count  = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      count_q <= '0;
      head_q  <= '0;
    end else begin
      cap_q   <= cap_d;
      count_q <= count_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    item_q       <= item_d;
    res_status_q <= res_status_d;
    res_val_q    <= res_val_d;
    res_pri_q    <= res_pri_d;
    out_q        <= out_d;
  end

  assign sts_o.is_deq   = (item_q.opcode == OP_DEQ);
  assign sts_o.full     = (count_q >= limit);
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.pos_zero = (pos_q == '0);
  assign sts_o.pos_one  = (pos_q == CNT_W'(1));
  assign sts_o.new_le   = (rd_pri <= item_q.item_priority);

  assign out_data_o = out_q;

endmodule

// File: hw/rtl/sorted_array_priority_queue_top.sv
// top level of the sorted array priority queue
//
// usage:
// - input channel (in_valid_i / in_stall_o / in_data_i) takes one word per
//   operation: enqueue of a value and priority, or dequeue of the head entry
// - output channel (out_valid_o / out_stall_i / out_data_o) returns one word
//   per operation: status, removed value and priority, entries held after it
// - capacity register is written through cfg_valid_i / cfg_ready_o /
//   cfg_data_i while no operation is in flight
// - entries live in a ring in one ram; the head pointer makes a dequeue a
//   single read, an enqueue walks down from the tail one entry per cycle
// - a refused operation or an enqueue into an empty queue goes from start
//   straight to done, a dequeue reads the head first, and an enqueue that
//   moves entries up walks them on the single ram write port first; the next
//   word is accepted in the cycle after the result is loaded
// - reset empties the queue and sets capacity to 64; ram contents are not
//   cleared, only entries below the count are ever read
// - a result sits in the output register while out_stall_i is high; the next
//   word is already accepted and worked on, and finishes once the register frees
module sorted_array_priority_queue_top #(
  parameter int unsigned DEPTH = sapq_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  sapq_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output sapq_pkg::out_item_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sapq_pkg::CNT_W-1:0] cfg_data_i
);
  import sapq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sapq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sapq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// File: hw/rtl/sapq_checker.sv
// port level checker of the priority queue, bound to the top level
`include "sorted_array_priority_queue_top_macros.svh"

module sapq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input sapq_pkg::in_item_t         in_data_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input sapq_pkg::out_item_t        out_data_o,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic [sapq_pkg::CNT_W-1:0] cfg_data_i
);
  import sapq_pkg::*;

  // no result word while reset is held
  `SAPQ_ASSERT_ALWAYS(a_rst_no_out, !rst_ni |-> !out_valid_o, "result shown during reset")

  // a stalled result word stays offered
  `SAPQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")

  // one operation at a time: an accepted word closes the input
  `SAPQ_ASSERT(a_one_at_a_time, in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o,
               "input reopened right after accept")

  // a refused operation carries no entry
  `SAPQ_ASSERT(a_refused_zero, out_valid_o && (out_data_o.status != ST_DONE) |->
               (out_data_o.out_value == '0) && (out_data_o.out_priority == '0),
               "refused result carries data")

  // an empty refusal leaves nothing held
  `SAPQ_ASSERT(a_empty_count, out_valid_o && (out_data_o.status == ST_EMPTY) |->
               (out_data_o.entry_count == '0), "empty refusal with entries held")

endmodule

bind sorted_array_priority_queue_top sapq_checker u_sapq_checker (.*);
